// ===== src/vertex_rotate_project_defines.svh =====
// -----------------------------------------------------------------------------
// Vertex rotate/project assertion macros
// Shared assertion forms for the vertex rotation and projection block.
// -----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define VRP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define VRP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/vrp_pkg.sv =====
// -----------------------------------------------------------------------------
// Vertex rotate/project package
// Fixed widths, register indexes, fixed-point constants and the sine series
// used to build the quarter-wave table at elaboration.
// -----------------------------------------------------------------------------
package vrp_pkg;

	localparam int ANGLE_W     = 10;
	localparam int ZOOM_W      = 16;
	localparam int SHIFT_W     = 16;
	localparam int OUT_W       = 32;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int ROM_W       = 17;
	localparam int TRIG_W      = 18;
	localparam int FRAC_BITS   = 15;
	localparam int COS30_Q15   = 28378;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ANGLE_X = 3'd0,
		REG_ANGLE_Y = 3'd1,
		REG_ANGLE_Z = 3'd2,
		REG_ISO     = 3'd3,
		REG_ZOOM    = 3'd4,
		REG_SHIFT_X = 3'd5,
		REG_SHIFT_Y = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_t;

	// Two Q30 multiplies of the running term by the argument.
	function automatic logic [63:0] series_term(input logic [63:0] term,
			input logic [63:0] arg);
		logic [63:0] t;
		t = (term * arg) >> 30;
		t = (t * arg) >> 30;
		return t;
	endfunction

	// Taylor series of sine for a Q30 argument in [0, pi/2], rounded to Q1.15.
	// Only ever evaluated on constants while the table is elaborated.
	function automatic logic [ROM_W-1:0] sine_series(input logic [63:0] arg);
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] q15;
		term = arg;
		sum  = signed'(arg);
		term = series_term(term, arg) / 64'd6;
		sum  = sum - signed'(term);
		term = series_term(term, arg) / 64'd20;
		sum  = sum + signed'(term);
		term = series_term(term, arg) / 64'd42;
		sum  = sum - signed'(term);
		term = series_term(term, arg) / 64'd72;
		sum  = sum + signed'(term);
		term = series_term(term, arg) / 64'd110;
		sum  = sum - signed'(term);
		term = series_term(term, arg) / 64'd156;
		sum  = sum + signed'(term);
		term = series_term(term, arg) / 64'd210;
		sum  = sum - signed'(term);
		term = series_term(term, arg) / 64'd272;
		sum  = sum + signed'(term);
		term = series_term(term, arg) / 64'd342;
		sum  = sum - signed'(term);
		if (sum < 64'sd0) begin
			sum = 64'sd0;
		end
		q15 = (sum + 64'sd16384) >>> 15;
		if (q15 > 64'sd32768) begin
			q15 = 64'sd32768;
		end
		return ROM_W'(q15);
	endfunction

endpackage

// ===== src/vertex_rotate_project.sv =====
// -----------------------------------------------------------------------------
// Vertex rotate/project
// Rotates one 3D world vertex about X, Y and Z, projects it isometrically or
// orthographically, then applies zoom and screen offset with saturation.
// -----------------------------------------------------------------------------
// The block takes one vertex in every clock cycle and gives its screen
// position as a one-cycle pulse on done, with screen_x and screen_y valid
// alongside. The receiver cannot hold results off, so nothing ever stalls:
// busy stays low and a new vertex may follow in the very next cycle, with
// up to eight vertices in flight. The eight register stages are angle decode,
// sine table lookup, rotation about X, about Y, about Z, projection, zoom
// multiply, and rounding with offset and saturation; the rotation stages
// each hold four parallel multipliers and set the clock. Configuration is
// written through cfg_we/cfg_index/cfg_data; a write in the same cycle as a
// vertex transfer already applies to that vertex. Writes to an unused index
// are ignored.
`include "vertex_rotate_project_defines.svh"

module vertex_rotate_project #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_STEPS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_WIDTH-1:0]        world_x,
	input  logic signed [COORD_WIDTH-1:0]        world_y,
	input  logic signed [COORD_WIDTH-1:0]        world_z,
	output logic                                 done,
	output logic signed [vrp_pkg::OUT_W-1:0]     screen_x,
	output logic signed [vrp_pkg::OUT_W-1:0]     screen_y,
	input  logic                                 cfg_we,
	input  logic [vrp_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [vrp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import vrp_pkg::*;

	// Angle decoding: an angle splits into a quadrant and a position inside
	// it. The quotient by the quarter turn comes from a reciprocal multiply
	// that may fall one short, fixed by a single compare and subtract.
	localparam int QUARTER     = ANGLE_STEPS / 4;
	localparam int IDX_W       = $clog2(QUARTER + 1);
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP       = (1 << RECIP_SHIFT) / QUARTER;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int QE_BITS     = $clog2(((1 << ANGLE_W) - 1) / QUARTER + 2);
	localparam int QE_W        = (QE_BITS < 2) ? 2 : QE_BITS;
	localparam int DPROD_W     = ANGLE_W + RECIP_W;

	// Datapath widths. Coordinates carry 15 fraction bits; the rotations are
	// near-orthogonal, so a vertex never grows past the length of its
	// diagonal and one guard bit on top of that is enough.
	localparam int CW   = COORD_WIDTH + 17;
	localparam int PRW  = CW + TRIG_W + 1;
	localparam int PW   = CW + 1;
	localparam int PISO = PW + 16;
	localparam int PZW  = PW + ZOOM_W + 1;
	localparam int SW   = PZW + 1;

	typedef struct packed {
		logic [1:0]       quad;
		logic [IDX_W-1:0] rem;
	} angle_dec_t;

	// Quarter-wave sine table, built from constants at elaboration.
	logic [ROM_W-1:0] sine_rom [QUARTER+1];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
		localparam logic [63:0] ARG = (64'(g) * HALF_PI_Q30) / 64'(QUARTER);
		assign sine_rom[g] = sine_series(ARG);
	end

	function automatic angle_dec_t decode_angle(input logic [ANGLE_W-1:0] a);
		logic [DPROD_W-1:0] prod;
		logic [QE_W-1:0]    qe;
		logic [ANGLE_W:0]   rem;
		angle_dec_t         d;
		prod = DPROD_W'(a) * DPROD_W'(RECIP);
		qe   = QE_W'(prod >> RECIP_SHIFT);
		rem  = (ANGLE_W + 1)'(a) - (ANGLE_W + 1)'(int'(qe) * QUARTER);
		if (rem >= (ANGLE_W + 1)'(QUARTER)) begin
			rem = rem - (ANGLE_W + 1)'(QUARTER);
			qe  = qe + QE_W'(1);
		end
		d.quad = qe[1:0];
		d.rem  = IDX_W'(rem);
		return d;
	endfunction

	function automatic logic signed [PRW-1:0] mul_t(input logic signed [CW-1:0] a,
			input logic signed [TRIG_W-1:0] b);
		return PRW'(a) * PRW'(b);
	endfunction

	// Round half up back to 15 fraction bits.
	function automatic logic signed [CW-1:0] rnd_c(input logic signed [PRW-1:0] v);
		return CW'((v + PRW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SW-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (!v[SW-1] && (|v[SW-2:OUT_W-1])) begin
			r = OUT_MAX;
		end else if (v[SW-1] && !(&v[SW-2:OUT_W-1])) begin
			r = OUT_MIN;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [ANGLE_W-1:0]        ang_q [3];
	logic                      iso_q;
	logic [ZOOM_W-1:0]         zoom_q;
	logic signed [SHIFT_W-1:0] shift_x_q;
	logic signed [SHIFT_W-1:0] shift_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q[0]  <= '0;
			ang_q[1]  <= '0;
			ang_q[2]  <= '0;
			iso_q     <= 1'b1;
			zoom_q    <= ZOOM_W'(256);
			shift_x_q <= '0;
			shift_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_X: ang_q[0]  <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_Y: ang_q[1]  <= cfg_data[ANGLE_W-1:0];
				REG_ANGLE_Z: ang_q[2]  <= cfg_data[ANGLE_W-1:0];
				REG_ISO:     iso_q     <= cfg_data[0];
				REG_ZOOM:    zoom_q    <= cfg_data[ZOOM_W-1:0];
				REG_SHIFT_X: shift_x_q <= signed'(cfg_data[SHIFT_W-1:0]);
				REG_SHIFT_Y: shift_y_q <= signed'(cfg_data[SHIFT_W-1:0]);
				default: ;
			endcase
		end
	end

	// The angle that a vertex entering now sees: a write in the same cycle
	// is forwarded so that the vertex is decoded with the new angle.
	logic [ANGLE_W-1:0] ang_n [3];

	always_comb begin
		ang_n[0] = (cfg_we && cfg_index == REG_ANGLE_X) ? cfg_data[ANGLE_W-1:0] : ang_q[0];
		ang_n[1] = (cfg_we && cfg_index == REG_ANGLE_Y) ? cfg_data[ANGLE_W-1:0] : ang_q[1];
		ang_n[2] = (cfg_we && cfg_index == REG_ANGLE_Z) ? cfg_data[ANGLE_W-1:0] : ang_q[2];
	end

	// ------------------------------------------------------------------
	// Valid bits. Every stage advances in every cycle.
	// ------------------------------------------------------------------
	logic accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the vertex and decode the three angles.
	// Stage 2: look up sine and cosine by quadrant symmetry.
	// ------------------------------------------------------------------
	logic signed [COORD_WIDTH-1:0] wx_s1, wy_s1, wz_s1;
	logic signed [COORD_WIDTH-1:0] wx_s2, wy_s2, wz_s2;
	angle_dec_t                    dec_s1  [3];
	trig_t                         trig_n  [3];
	trig_t                         trig_s2 [3];

	// Cosine uses the next quadrant at the same position, so the sine and
	// cosine magnitudes are the table entries at rem and QUARTER-rem,
	// swapped in the odd quadrants.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [ROM_W-1:0]         lo_mag;
			logic [ROM_W-1:0]         hi_mag;
			logic signed [TRIG_W-1:0] s_mag;
			logic signed [TRIG_W-1:0] c_mag;
			lo_mag = sine_rom[dec_s1[k].rem];
			hi_mag = sine_rom[IDX_W'(QUARTER) - dec_s1[k].rem];
			s_mag  = signed'(TRIG_W'(dec_s1[k].quad[0] ? hi_mag : lo_mag));
			c_mag  = signed'(TRIG_W'(dec_s1[k].quad[0] ? lo_mag : hi_mag));
			trig_n[k].sin_v = dec_s1[k].quad[1] ? -s_mag : s_mag;
			trig_n[k].cos_v = (dec_s1[k].quad[1] ^ dec_s1[k].quad[0]) ? -c_mag : c_mag;
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= world_x;
		wy_s1 <= world_y;
		wz_s1 <= world_z;
		for (int k = 0; k < 3; k++) begin
			dec_s1[k]  <= decode_angle(ang_n[k]);
			trig_s2[k] <= trig_n[k];
		end
		wx_s2 <= wx_s1;
		wy_s2 <= wy_s1;
		wz_s2 <= wz_s1;
	end

	// ------------------------------------------------------------------
	// Stages 3 to 5: rotation about X, then Y, then Z, each rounded back
	// to 15 fraction bits. Trig values for later stages travel with the
	// vertex.
	// ------------------------------------------------------------------
	logic signed [CW-1:0] x0, y0, z0;
	logic signed [CW-1:0] x_s3, y_s3, z_s3;
	logic signed [CW-1:0] x_s4, y_s4, z_s4;
	logic signed [CW-1:0] x_s5, y_s5, z_s5;
	trig_t                trig_y_s3, trig_z_s3, trig_z_s4;

	assign x0 = CW'(wx_s2) <<< FRAC_BITS;
	assign y0 = CW'(wy_s2) <<< FRAC_BITS;
	assign z0 = CW'(wz_s2) <<< FRAC_BITS;

	always_ff @(posedge clk) begin
		// About X: y' = y*c + z*s, z' = z*c - y*s.
		x_s3 <= x0;
		y_s3 <= rnd_c(mul_t(y0, trig_s2[0].cos_v) + mul_t(z0, trig_s2[0].sin_v));
		z_s3 <= rnd_c(mul_t(z0, trig_s2[0].cos_v) - mul_t(y0, trig_s2[0].sin_v));
		trig_y_s3 <= trig_s2[1];
		trig_z_s3 <= trig_s2[2];

		// About Y: x' = x*c + z*s, z' = z*c - x*s.
		x_s4 <= rnd_c(mul_t(x_s3, trig_y_s3.cos_v) + mul_t(z_s3, trig_y_s3.sin_v));
		y_s4 <= y_s3;
		z_s4 <= rnd_c(mul_t(z_s3, trig_y_s3.cos_v) - mul_t(x_s3, trig_y_s3.sin_v));
		trig_z_s4 <= trig_z_s3;

		// About Z: x' = x*c - y*s, y' = x*s + y*c.
		x_s5 <= rnd_c(mul_t(x_s4, trig_z_s4.cos_v) - mul_t(y_s4, trig_z_s4.sin_v));
		y_s5 <= rnd_c(mul_t(x_s4, trig_z_s4.sin_v) + mul_t(y_s4, trig_z_s4.cos_v));
		z_s5 <= z_s4;
	end

	// ------------------------------------------------------------------
	// Stage 6: projection. Multiplying by sin30 (one half in Q1.15) and
	// rounding half up reduces to (x + y + 1) >> 1.
	// ------------------------------------------------------------------
	logic signed [PW-1:0]   iso_d;
	logic signed [PISO-1:0] iso_p;
	logic signed [PW-1:0]   sx_n, sy_n;
	logic signed [PW-1:0]   sx_s6, sy_s6;

	always_comb begin
		iso_d = PW'(x_s5) - PW'(y_s5);
		iso_p = PISO'(iso_d) * PISO'(COS30_Q15);
		if (iso_q) begin
			sx_n = PW'((iso_p + PISO'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
			sy_n = ((PW'(x_s5) + PW'(y_s5) + PW'(1)) >>> 1) - PW'(z_s5);
		end else begin
			sx_n = PW'(x_s5);
			sy_n = PW'(y_s5);
		end
	end

	always_ff @(posedge clk) begin
		sx_s6 <= sx_n;
		sy_s6 <= sy_n;
	end

	// ------------------------------------------------------------------
	// Stage 7: zoom multiply (Q.15 times Q8.8 gives Q.23).
	// Stage 8: round to Q.8, add the offset in whole pixels, saturate.
	// ------------------------------------------------------------------
	logic signed [PZW-1:0]   zx_s7, zy_s7;
	logic signed [PZW-1:0]   zx_r, zy_r;
	logic signed [SW-1:0]    off_x, off_y;
	logic signed [OUT_W-1:0] sx_s8, sy_s8;

	always_ff @(posedge clk) begin
		zx_s7 <= PZW'(sx_s6) * signed'(PZW'(zoom_q));
		zy_s7 <= PZW'(sy_s6) * signed'(PZW'(zoom_q));
	end

	assign zx_r  = (zx_s7 + PZW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign zy_r  = (zy_s7 + PZW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign off_x = SW'(shift_x_q) <<< 8;
	assign off_y = SW'(shift_y_q) <<< 8;

	always_ff @(posedge clk) begin
		sx_s8 <= sat_out(SW'(zx_r) + off_x);
		sy_s8 <= sat_out(SW'(zy_r) + off_y);
	end

	assign done     = v_s8;
	assign screen_x = sx_s8;
	assign screen_y = sy_s8;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`VRP_ASSERT_IMP(a_latency, accept, ##8 done, "vertex transfer without result eight cycles later")
	`VRP_ASSERT_IMP(a_rem_range, v_s1, dec_s1[0].rem < QUARTER && dec_s1[1].rem < QUARTER && dec_s1[2].rem < QUARTER, "angle decode left a position outside its quadrant")
	`VRP_ASSERT_IMP(a_zero_zoom, done && zoom_q == '0, screen_x == off_x && screen_y == off_y, "zero zoom did not give the offsets")

endmodule
